// ===== rtl/gtcw_pkg.sv =====
`default_nettype none
package gtcw_pkg;

	// Font store geometry
	localparam int GLYPH_ROWS  = 16;
	localparam int GLYPH_COUNT = 256;
	localparam int FONT_DEPTH  = GLYPH_COUNT * GLYPH_ROWS;
	localparam int FONT_AW     = $clog2(FONT_DEPTH);
	// flat index before the range check: code * GLYPH_ROWS + row, with headroom
	localparam int FULL_AW     = 8 + $clog2(GLYPH_ROWS) + 1;

	// Character cell
	localparam int CELL_ROWS   = 16;
	localparam int ROW_CW      = $clog2(CELL_ROWS);
	localparam logic [11:0] CELL_WIDTH = 12'd8;
	localparam logic [11:0] CELL_HEIGHT = 12'd16;

	// Command queue between front and back
	localparam int QUEUE_DEPTH = 2;
	localparam int QUEUE_PW    = $clog2(QUEUE_DEPTH);
	localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

	// Register reset values
	localparam logic [11:0] SCREEN_WIDTH_RST = 12'd640;
	localparam logic [11:0] LINE_STRIDE_RST  = 12'd640;
	localparam logic [11:0] CURSOR_RST       = 12'd8;

	typedef enum logic [1:0] {
		MODE_PUT       = 2'd0,
		MODE_NEWLINE   = 2'd1,
		MODE_BACKSPACE = 2'd2,
		MODE_LOAD      = 2'd3
	} mode_t;

	typedef enum logic {
		REG_SCREEN_WIDTH = 1'b0,
		REG_LINE_STRIDE  = 1'b1
	} reg_index_t;

	typedef enum logic [1:0] {
		JOB_PUT   = 2'd0,
		JOB_CLEAR = 2'd1,
		JOB_LOAD  = 2'd2
	} job_kind_t;

	typedef struct packed {
		mode_t       mode;
		logic [7:0]  code;
		logic [3:0]  glyph_row;
		logic [7:0]  row_bits;
		logic [23:0] color;
	} cmd_t;

	typedef struct packed {
		logic [11:0] pixel_x;
		logic [11:0] pixel_y;
		logic [23:0] word_offset;
		logic [7:0]  pixel_mask;
		logic [23:0] pixel_color;
		logic        last;
	} row_write_t;

	typedef struct packed {
		job_kind_t   kind;
		logic [11:0] x;
		logic [11:0] y;
		logic [7:0]  code;
		logic [3:0]  glyph_row;
		logic [7:0]  row_bits;
		logic [23:0] color;
	} job_t;

endpackage
`default_nettype wire

// ===== rtl/gtcw_front.sv =====
`default_nettype none
module gtcw_front
	import gtcw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        accept,
	input  wire cmd_t        cmd,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data,
	output logic             push,
	output job_t             job,
	output logic [11:0]      line_stride
);

	logic [11:0] screen_width_q;
	logic [11:0] line_stride_q;
	logic [11:0] cursor_x_q;
	logic [11:0] cursor_y_q;

	logic [11:0] nx;
	logic [11:0] ny;
	logic [11:0] put_x;
	logic [11:0] bs_x;
	logic [11:0] bs_y;
	logic [11:0] bs_y_up;

	assign line_stride = line_stride_q;

	always_comb begin
		nx      = cursor_x_q;
		ny      = cursor_y_q;
		push    = 1'b0;
		put_x   = cursor_x_q + CELL_WIDTH;
		bs_x    = cursor_x_q;
		bs_y    = cursor_y_q;
		bs_y_up = 12'd0;
		job.kind      = JOB_PUT;
		job.x         = cursor_x_q;
		job.y         = cursor_y_q;
		job.code      = cmd.code;
		job.glyph_row = cmd.glyph_row;
		job.row_bits  = cmd.row_bits;
		job.color     = cmd.color;

		// backspace at column zero goes up a line first
		if (cursor_x_q == 12'd0) begin
			bs_x = screen_width_q;
			bs_y = (cursor_y_q >= CELL_HEIGHT) ? cursor_y_q - CELL_HEIGHT : 12'd0;
		end
		bs_y_up = (bs_y >= CELL_HEIGHT) ? bs_y - CELL_HEIGHT : 12'd0;

		case (cmd.mode)
			MODE_PUT: begin
				push = accept;
				if ({1'b0, put_x} + {1'b0, CELL_WIDTH} > {1'b0, screen_width_q}) begin
					nx = CURSOR_RST;
					ny = cursor_y_q + CELL_HEIGHT;
				end else begin
					nx = put_x;
				end
			end
			MODE_NEWLINE: begin
				nx = CURSOR_RST;
				ny = cursor_y_q + CELL_HEIGHT;
			end
			MODE_BACKSPACE: begin
				push      = accept;
				job.kind  = JOB_CLEAR;
				job.x     = bs_x - CELL_WIDTH;
				job.y     = bs_y;
				job.color = 24'd0;
				if (bs_x < CELL_WIDTH) begin
					nx = screen_width_q;
					ny = bs_y_up;
				end else begin
					nx = bs_x - CELL_WIDTH;
					ny = bs_y;
				end
			end
			MODE_LOAD: begin
				job.kind = JOB_LOAD;
				push     = accept && ({1'b0, cmd.glyph_row} < 5'(GLYPH_ROWS))
				           && ({2'b0, cmd.code} < 10'(GLYPH_COUNT));
			end
			default: begin
				push = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cursor_x_q <= CURSOR_RST;
			cursor_y_q <= CURSOR_RST;
		end else if (accept) begin
			cursor_x_q <= nx;
			cursor_y_q <= ny;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			screen_width_q <= SCREEN_WIDTH_RST;
			line_stride_q  <= LINE_STRIDE_RST;
		end else if (cfg_we) begin
			case (reg_index_t'(cfg_index))
				REG_SCREEN_WIDTH: screen_width_q <= cfg_data;
				REG_LINE_STRIDE:  line_stride_q  <= cfg_data;
				default: begin
				end
			endcase
		end
	end

endmodule
`default_nettype wire

// ===== rtl/gtcw_queue.sv =====
`default_nettype none
module gtcw_queue
	import gtcw_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output logic      full,
	output logic      valid,
	output job_t      head
);

	job_t                entry_q [QUEUE_DEPTH];
	logic [QUEUE_PW-1:0] wr_ptr_q;
	logic [QUEUE_PW-1:0] rd_ptr_q;
	logic [QUEUE_CW-1:0] count_q;

	assign full  = (count_q == QUEUE_CW'(QUEUE_DEPTH));
	assign valid = (count_q != '0);
	assign head  = entry_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n)
		!(push && full)) else $error("queue overrun");
	assert property (@(posedge clk) disable iff (!arst_n)
		!(pop && !valid)) else $error("queue underrun");

endmodule
`default_nettype wire

// ===== rtl/gtcw_back.sv =====
`default_nettype none
module gtcw_back
	import gtcw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_valid,
	input  wire job_t        q_head,
	input  wire logic [11:0] line_stride,
	output logic             pop,
	output logic             strobe,
	output row_write_t       pixel_row
);

	logic [7:0]        font_mem [FONT_DEPTH];

	logic              active_q;
	logic [ROW_CW-1:0] row_q;
	job_t              job_q;
	logic              last_row;
	logic [FULL_AW-1:0] rd_full;

	logic              valid_s1;
	logic [11:0]       x_s1;
	logic [11:0]       y_s1;
	logic [23:0]       color_s1;
	logic              clear_s1;
	logic              in_range_s1;
	logic              last_s1;
	logic [7:0]        rd_s1;

	logic              strobe_q;
	row_write_t        row_q_out;
	logic [23:0]       offset;

	assign last_row = (row_q == ROW_CW'(CELL_ROWS - 1));
	assign pop      = q_valid && (!active_q || last_row);
	assign rd_full  = FULL_AW'(job_q.code) * FULL_AW'(GLYPH_ROWS) + FULL_AW'(row_q);

	// font writes come in queue order, so a draw never sees a later load
	always_ff @(posedge clk) begin
		if (pop && q_head.kind == JOB_LOAD) begin
			font_mem[FONT_AW'(FULL_AW'(q_head.code) * FULL_AW'(GLYPH_ROWS)
				+ FULL_AW'(q_head.glyph_row))] <= q_head.row_bits;
		end
		rd_s1 <= font_mem[rd_full[FONT_AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			row_q    <= '0;
		end else if (pop && q_head.kind != JOB_LOAD) begin
			active_q <= 1'b1;
			row_q    <= '0;
		end else if (active_q && last_row) begin
			active_q <= 1'b0;
		end else if (active_q) begin
			row_q <= row_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (pop && q_head.kind != JOB_LOAD) begin
			job_q <= q_head;
		end
		x_s1        <= job_q.x;
		y_s1        <= job_q.y + 12'(row_q);
		color_s1    <= job_q.color;
		clear_s1    <= (job_q.kind == JOB_CLEAR);
		in_range_s1 <= (rd_full < FULL_AW'(FONT_DEPTH));
		last_s1     <= last_row;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			strobe_q <= 1'b0;
		end else begin
			valid_s1 <= active_q;
			strobe_q <= valid_s1;
		end
	end

	// offset kept to 24 bits
	assign offset = {12'd0, line_stride} * {12'd0, y_s1} + {12'd0, x_s1};

	always_ff @(posedge clk) begin
		row_q_out.pixel_x     <= x_s1;
		row_q_out.pixel_y     <= y_s1;
		row_q_out.word_offset <= offset;
		row_q_out.pixel_mask  <= clear_s1 ? 8'hFF : (in_range_s1 ? rd_s1 : 8'h00);
		row_q_out.pixel_color <= color_s1;
		row_q_out.last        <= last_s1;
	end

	assign strobe    = strobe_q;
	assign pixel_row = row_q_out;

	assert property (@(posedge clk) disable iff (!arst_n)
		active_q && !last_row |=> active_q && row_q == $past(row_q) + 1'b1)
		else $error("row counter skipped");
	assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && row_q_out.last |-> $past(strobe_q, CELL_ROWS - 1))
		else $error("cell ended short of its rows");
	assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> strobe_q) else $error("row write lost");

endmodule
`default_nettype wire

// ===== rtl/glyph_text_console_writer_top.sv =====
`default_nettype none
// Channel   | Ports                          | Transfer
// ----------+--------------------------------+------------------------------------
// command   | start, busy, cmd               | edge with start high and busy low
// row write | strobe, pixel_row              | edge ending the cycle strobe is high
// config    | cfg_we, cfg_index, cfg_data    | edge with cfg_we high
//
// Put and backspace each give 16 row writes, one per cycle, set by the back end
// reading one font row per cycle; the first passes the queue, the row counter, the
// font read stage and output register. Newline is not queued; a load is written on pop.
// busy rises only while the 2-entry command queue is full.
// Reset: cursor at (8,8), width and stride 640; font store undefined until loaded.
// Row writes cannot be stalled by the receiver.
module glyph_text_console_writer_top
	import gtcw_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        start,
	input  wire cmd_t        cmd,
	output logic             busy,
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [11:0] cfg_data,
	output logic             strobe,
	output row_write_t       pixel_row
);

	logic        accept;
	logic        push;
	job_t        job;
	logic [11:0] line_stride;
	logic        q_full;
	logic        q_valid;
	job_t        q_head;
	logic        pop;

	// front end: cursor tracking, config, classification of commands
	assign accept = start && !q_full;
	assign busy   = q_full;

	gtcw_front u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.accept      (accept),
		.cmd         (cmd),
		.cfg_we      (cfg_we),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.push        (push),
		.job         (job),
		.line_stride (line_stride)
	);

	// decoupling queue: loads and draws stay in order
	gtcw_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (job),
		.pop      (pop),
		.full     (q_full),
		.valid    (q_valid),
		.head     (q_head)
	);

	// back end: font store and row-write generator
	gtcw_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.q_valid     (q_valid),
		.q_head      (q_head),
		.line_stride (line_stride),
		.pop         (pop),
		.strobe      (strobe),
		.pixel_row   (pixel_row)
	);

endmodule
`default_nettype wire
